// File: rtl/core/lcd_marquee_scroller_top_assert.svh
// Assertion macros for the checker of the marquee scroller.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef LCD_MARQUEE_SCROLLER_TOP_ASSERT_SVH
`define LCD_MARQUEE_SCROLLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge and ignored in reset.
`define LMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and ignored in reset.
`define LMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/lms_pkg.sv
// Package of the LCD marquee scroller: constants, codes, FSM state type and
// the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lms_pkg;

	localparam int MSG_DEPTH_DEF   = 128;
	localparam int LCD_COLUMNS_DEF = 16;
	localparam int PAD_SPACES      = 3;
	localparam int MAX_RUN         = 16;
	localparam int RUN_W           = $clog2(MAX_RUN + 1);

	localparam logic [1:0] HOLD_TICKS   = 2'd3;
	localparam logic [7:0] SPACE_CHAR   = 8'h20;
	localparam logic [4:0] WIDTH_RESET  = 5'd16;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_TICK   = 1'b1;
	localparam logic KIND_CURSOR = 1'b0;
	localparam logic KIND_CHAR   = 1'b1;

	typedef enum logic [1:0] {
		CFG_ROW   = 2'd0,
		CFG_COL   = 2'd1,
		CFG_WIDTH = 2'd2,
		CFG_PAUSE = 2'd3
	} lms_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_RUN
	} lms_state_t;

	typedef struct packed {
		logic accept;
		logic pad_wr;
		logic emit_cmd;
		logic issue;
		logic move;
	} lms_cmd_t;

	typedef struct packed {
		logic load_end;
		logic tick_go;
		logic pad_done;
		logic out_free;
		logic cmd_pend;
		logic remain_nz;
		logic pend;
	} lms_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/lms_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/lms_ctrl.sv
// Controller FSM of the LCD marquee scroller: sequences loads, padding and
// the output run. Depends on lms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lms_ctrl
	import lms_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire lms_stat_t stat,
	output lms_cmd_t       cmd
);

	lms_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.load_end) begin
					state_nxt = ST_PAD;
				end else if (in_valid && stat.tick_go) begin
					state_nxt = ST_RUN;
				end
			end
			ST_PAD: begin
				if (stat.pad_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_RUN: begin
				if (!stat.cmd_pend && !stat.remain_nz && !stat.pend) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_PAD: begin
				cmd.pad_wr = 1'b1;
			end
			ST_RUN: begin
				// The cursor command goes out first; characters follow behind it.
				cmd.emit_cmd = stat.cmd_pend && stat.out_free;
				cmd.move     = stat.pend && stat.out_free && !stat.cmd_pend;
				cmd.issue    = stat.remain_nz && (!stat.pend || cmd.move);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/lms_dp.sv
// Datapath of the LCD marquee scroller: configuration, message store,
// scroll state, read pipeline and output register. Depends on lms_pkg, lms_ram.
`timescale 1ns / 1ps
`default_nettype none

module lms_dp
	import lms_pkg::*;
#(
	parameter int MSG_DEPTH   = MSG_DEPTH_DEF,
	parameter int LCD_COLUMNS = LCD_COLUMNS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic [1:0] cfg_index,
	input  wire logic [4:0] cfg_data,
	input  wire logic       mode,
	input  wire logic [7:0] char_in,
	input  wire logic       last_char,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            kind,
	output logic [1:0]      out_row,
	output logic [3:0]      out_col,
	output logic [7:0]      char_out,
	output logic            last,
	input  wire lms_cmd_t   cmd,
	output lms_stat_t       stat
);

	localparam int PTR_W = $clog2(MSG_DEPTH);
	localparam int LEN_W = $clog2(MSG_DEPTH + 1);
	localparam int COL_W = $clog2(LCD_COLUMNS + 1);
	localparam int CMP_W = (COL_W > RUN_W) ? COL_W : RUN_W;
	localparam logic [LEN_W-1:0] KEEP_MAX = LEN_W'(MSG_DEPTH - PAD_SPACES);
	localparam logic [1:0] PAD_LAST = 2'(PAD_SPACES - 1);

	// Configuration registers.
	logic [1:0] cfg_row_q;
	logic [3:0] cfg_col_q;
	logic [4:0] cfg_width_q;
	logic       cfg_pause_q;

	// Message and scroll state.
	logic [LEN_W-1:0] len_q;
	logic [PTR_W-1:0] wp_q;
	logic             loading_q;
	logic [PTR_W-1:0] start_q;
	logic [1:0]       hold_q;
	logic             holding_q;
	logic [1:0]       pad_cnt_q;

	// Run state.
	logic             cmd_pend_q;
	logic [RUN_W-1:0] remain_q;
	logic             pend_q;
	logic             pend_last_q;
	logic [PTR_W-1:0] idx_q;
	logic             zero_q;
	logic             out_valid_q;
	logic             kind_q;
	logic [1:0]       row_q;
	logic [3:0]       col_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic             load_acc;
	logic             tick_acc;
	logic [PTR_W-1:0] wp_base;
	logic             room_ok;
	logic [PTR_W-1:0] wp_next;
	logic [LEN_W-1:0] len_new;
	logic [CMP_W-1:0] col_ext;
	logic [CMP_W-1:0] room;
	logic [CMP_W-1:0] w_clip;
	logic [RUN_W-1:0] width_eff;
	logic [PTR_W-1:0] start_inc;
	logic [PTR_W-1:0] idx_inc;
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	assign load_acc = cmd.accept && (mode == MODE_LOAD);
	assign tick_acc = cmd.accept && stat.tick_go;

	// A load that starts a new message restarts the write pointer.
	assign wp_base = loading_q ? wp_q : '0;
	assign room_ok = LEN_W'(wp_base) < KEEP_MAX;
	assign wp_next = room_ok ? wp_base + PTR_W'(1) : wp_base;
	assign len_new = LEN_W'(wp_next) + LEN_W'(PAD_SPACES);

	// Window width clamped to the columns left and to the longest run.
	assign col_ext   = CMP_W'(cfg_col_q);
	assign room      = (col_ext < CMP_W'(LCD_COLUMNS)) ? CMP_W'(LCD_COLUMNS) - col_ext : '0;
	assign w_clip    = (CMP_W'(cfg_width_q) > room) ? room : CMP_W'(cfg_width_q);
	assign width_eff = (w_clip > CMP_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : RUN_W'(w_clip);

	assign start_inc = ((LEN_W'(start_q) + LEN_W'(1)) >= len_q) ? '0 : start_q + PTR_W'(1);
	assign idx_inc   = ((LEN_W'(idx_q) + LEN_W'(1)) >= len_q) ? '0 : idx_q + PTR_W'(1);

	assign ram_we    = cmd.pad_wr || (load_acc && room_ok);
	assign ram_waddr = cmd.pad_wr ? wp_q + PTR_W'(pad_cnt_q) : wp_base;
	assign ram_wdata = cmd.pad_wr ? SPACE_CHAR : char_in;

	lms_ram #(
		.WIDTH(8),
		.DEPTH(MSG_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.issue),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		stat.load_end  = (mode == MODE_LOAD) && last_char;
		stat.tick_go   = (mode == MODE_TICK) && !cfg_pause_q && (len_q != '0);
		stat.pad_done  = (pad_cnt_q == PAD_LAST);
		stat.out_free  = !out_valid_q || out_ready;
		stat.cmd_pend  = cmd_pend_q;
		stat.remain_nz = (remain_q != '0);
		stat.pend      = pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_row_q   <= '0;
			cfg_col_q   <= '0;
			cfg_width_q <= WIDTH_RESET;
			cfg_pause_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW:   cfg_row_q   <= cfg_data[1:0];
				CFG_COL:   cfg_col_q   <= cfg_data[3:0];
				CFG_WIDTH: cfg_width_q <= cfg_data;
				CFG_PAUSE: cfg_pause_q <= cfg_data[0];
				default:   cfg_pause_q <= cfg_pause_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			wp_q       <= '0;
			loading_q  <= 1'b0;
			start_q    <= '0;
			hold_q     <= '0;
			holding_q  <= 1'b0;
			pad_cnt_q  <= '0;
		end else begin
			if (load_acc) begin
				wp_q <= wp_next;
				if (last_char) begin
					len_q     <= len_new;
					start_q   <= '0;
					hold_q    <= HOLD_TICKS;
					holding_q <= 1'b1;
					loading_q <= 1'b0;
				end else begin
					loading_q <= 1'b1;
					if (!loading_q) begin
						len_q <= '0;
					end
				end
			end
			if (tick_acc) begin
				if (holding_q && (hold_q != 2'd0)) begin
					hold_q <= hold_q - 2'd1;
				end else begin
					holding_q <= 1'b0;
					start_q   <= start_inc;
				end
			end
			if (cmd.pad_wr) begin
				pad_cnt_q <= stat.pad_done ? 2'd0 : pad_cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_pend_q  <= 1'b0;
			remain_q    <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				cmd_pend_q <= 1'b1;
				remain_q   <= width_eff;
			end else if (cmd.emit_cmd) begin
				cmd_pend_q <= 1'b0;
			end
			if (cmd.issue) begin
				remain_q <= remain_q - RUN_W'(1);
				pend_q   <= 1'b1;
			end else if (cmd.move) begin
				pend_q <= 1'b0;
			end
			if (cmd.emit_cmd || cmd.move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			idx_q  <= start_q;
			zero_q <= (width_eff == '0);
		end else if (cmd.issue) begin
			idx_q <= idx_inc;
		end
		if (cmd.issue) begin
			pend_last_q <= (remain_q == RUN_W'(1));
		end
		if (cmd.emit_cmd) begin
			kind_q <= KIND_CURSOR;
			row_q  <= cfg_row_q;
			col_q  <= cfg_col_q;
			char_q <= '0;
			last_q <= zero_q;
		end else if (cmd.move) begin
			kind_q <= KIND_CHAR;
			row_q  <= '0;
			col_q  <= '0;
			char_q <= ram_rdata;
			last_q <= pend_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign char_out  = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// File: rtl/core/lcd_marquee_scroller_top.sv
// LCD text marquee. Load requests (mode 0) write message characters into an
// internal store of MSG_DEPTH bytes; the request flagged last_char ends the
// message, appends three spaces and restarts the scroll with a hold of three
// extra ticks. Characters past MSG_DEPTH-3 are dropped, but a dropped one that
// carries last_char still ends the message. Each tick request (mode 1) that
// arrives while scrolling is not paused and a message exists produces one
// cursor command (kind 0) followed by the window's characters (kind 1), the
// last of them flagged; the window width is clamped to LCD_COLUMNS minus the
// cursor column and to sixteen. After a final load request the padding spaces
// are written one at a time through the store's single write port, and no
// request is accepted meanwhile. The store's one registered read port
// delivers one character per cycle while the output is not stalled. A finished
// result sits in an output register, so the input side is free again while it
// waits to be taken. The store needs no clearing after reset. Configuration
// writes (cursor_row, cursor_col, window_width, paused at indexes 0 to 3) are
// always accepted and must only be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module lcd_marquee_scroller_top
	import lms_pkg::*;
#(
	parameter int MSG_DEPTH   = MSG_DEPTH_DEF,
	parameter int LCD_COLUMNS = LCD_COLUMNS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Configuration write channel.
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [4:0] cfg_data,
	// Input request channel.
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       mode,
	input  wire logic [7:0] char_in,
	input  wire logic       last_char,
	// Result channel.
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            kind,
	output logic [1:0]      out_row,
	output logic [3:0]      out_col,
	output logic [7:0]      char_out,
	output logic            last
);

	lms_cmd_t  cmd;
	lms_stat_t stat;

	// Register writes are always accepted.
	assign cfg_ready = 1'b1;

	// The controller owns the request handshake and sequences the datapath.
	lms_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// The datapath holds the store, the scroll state and the output register.
	lms_dp #(
		.MSG_DEPTH  (MSG_DEPTH),
		.LCD_COLUMNS(LCD_COLUMNS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.mode     (mode),
		.char_in  (char_in),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.out_row  (out_row),
		.out_col  (out_col),
		.char_out (char_out),
		.last     (last),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

`default_nettype wire

// File: rtl/core/lcd_marquee_scroller_chk.sv
// Port-level checker of the LCD marquee scroller and its bind to the top level.
// Depends on lms_pkg and lcd_marquee_scroller_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "lcd_marquee_scroller_top_assert.svh"

module lcd_marquee_scroller_chk
	import lms_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [4:0] cfg_data,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       mode,
	input wire logic [7:0] char_in,
	input wire logic       last_char,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       kind,
	input wire logic [1:0] out_row,
	input wire logic [3:0] out_col,
	input wire logic [7:0] char_out,
	input wire logic       last
);

	logic [15:0] res_bits;
	logic        out_stall;
	logic        char_res;
	logic        cursor_res;
	logic        run_cont;

	assign res_bits   = {kind, out_row, out_col, char_out, last};
	assign out_stall  = out_valid && !out_ready;
	assign char_res   = out_valid && (kind == KIND_CHAR);
	assign cursor_res = out_valid && (kind == KIND_CURSOR);
	assign run_cont   = cursor_res && out_ready && !last;

	// A stalled result keeps its contents.
	`LMS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(res_bits), "result not held")

	// Character results carry no cursor position.
	`LMS_ASSERT_NOW(a_char_pos, char_res, {out_row, out_col} == 6'd0, "character with a position")

	// Cursor commands carry no character byte.
	`LMS_ASSERT_NOW(a_cursor_char, cursor_res, char_out == 8'd0, "cursor with a character")

	// A cursor command that does not end its run is not followed at once by another cursor command.
	`LMS_ASSERT_NEXT(a_run_order, run_cont, !cursor_res, "no character after cursor")

endmodule

bind lcd_marquee_scroller_top lcd_marquee_scroller_chk u_chk (.*);

`default_nettype wire
